### rtl/hkec_pkg.sv
package hkec_pkg;

    localparam int TABLE_SLOTS  = 16384;
    localparam int PROBE_LIMIT  = 64;
    localparam int COUNT_BITS   = 32;

    localparam int IDX_W        = $clog2(TABLE_SLOTS);
    localparam int PROBE_W      = $clog2(PROBE_LIMIT + 1);

    localparam int KEY_W        = 64;
    localparam int SLOT_W       = 14;
    localparam int CNT_OUT_W    = 32;
    localparam int STATUS_W     = 2;

    localparam logic [63:0] HASH_MULT    = 64'h9E37_79B9_7F4A_7C15;
    localparam int          KEY_PRESHIFT = 4;

    localparam int IN_TDATA_W   = 80;
    localparam int OUT_TDATA_W  = 176;

    localparam logic [STATUS_W-1:0] STAT_RECORDED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO_KEY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_READ     = 2'd3;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        t_count            mm;
        t_count            hit;
        t_count            eval;
        logic [KEY_W-1:0]  key;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [SLOT_W-1:0]    slot;
        logic [KEY_W-1:0]     key;
        logic [CNT_OUT_W-1:0] eval;
        logic [CNT_OUT_W-1:0] hit;
        logic [CNT_OUT_W-1:0] mm;
    } t_result;

    function automatic t_count sat_inc(input t_count v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [OUT_TDATA_W-1:0] pack_out(input t_result r);
        logic [OUT_TDATA_W-1:0] d;
        d = '0;
        d[SLOT_W-1:0]                                  = r.slot;
        d[SLOT_W +: KEY_W]                             = r.key;
        d[SLOT_W+KEY_W +: CNT_OUT_W]                   = r.eval;
        d[SLOT_W+KEY_W+CNT_OUT_W +: CNT_OUT_W]         = r.hit;
        d[SLOT_W+KEY_W+2*CNT_OUT_W +: CNT_OUT_W]       = r.mm;
        return d;
    endfunction

endpackage

### rtl/hkec_ram.sv
module hkec_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hkec_hash.sv
module hkec_hash (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [hkec_pkg::KEY_W-1:0] i_key,
    output logic                       o_done,
    output logic [hkec_pkg::IDX_W-1:0] o_slot
);
    import hkec_pkg::*;

    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_LO   = 2'd1;
    localparam logic [1:0] STEP_MID  = 2'd2;
    localparam logic [1:0] STEP_HI   = 2'd3;

    logic [1:0]  r_step;
    logic        r_done;
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [63:0] r_acc;

    logic [63:0] w_shifted;
    logic [31:0] w_opa;
    logic [31:0] w_opb;
    logic [63:0] w_prod;

    assign w_shifted = i_key >> KEY_PRESHIFT;

    // (a + b*2^32) * (ml + mh*2^32) mod 2^64 = a*ml + ((a*mh + b*ml) << 32)
    always_comb begin
        w_opa = r_a;
        w_opb = HASH_MULT[31:0];
        case (r_step)
            STEP_MID: begin
                w_opb = HASH_MULT[63:32];
            end
            STEP_HI: begin
                w_opa = r_b;
            end
            default: begin
                w_opa = r_a;
            end
        endcase
    end

    assign w_prod = w_opa * w_opb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_step == STEP_HI);
            case (r_step)
                STEP_IDLE: if (i_start) r_step <= STEP_LO;
                STEP_LO:   r_step <= STEP_MID;
                STEP_MID:  r_step <= STEP_HI;
                STEP_HI:   r_step <= STEP_IDLE;
                default:   r_step <= STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_step)
            STEP_IDLE: begin
                r_a <= w_shifted[31:0];
                r_b <= w_shifted[63:32];
            end
            STEP_LO: begin
                r_acc <= w_prod;
            end
            default: begin
                r_acc[63:32] <= r_acc[63:32] + w_prod[31:0];
            end
        endcase
    end

    assign o_done = r_done;
    assign o_slot = r_acc[63 -: IDX_W];

endmodule

### rtl/hashed_key_event_counter.sv
// Record beat: after a shared-multiplier hash (steps LO, MID, HI) the table is probed
//   from the home slot, one probe per cycle through the table memory's read port, up to
//   PROBE_LIMIT probes; the result is registered when a slot matches or is empty.
// Read beat: slot read in ST_READ. Zero-key record: result at accept if output free.
// One item in flight; the next is accepted the cycle after its result is registered.
// Reset: synchronous, active low; then a clearing pass writes zero to all TABLE_SLOTS
//   (16384) slots with o_s_axis_tready low.
module hashed_key_event_counter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // key[63:0], hit_flag[64], mismatch_flag[65], read_slot[79:66]
    input  logic [hkec_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // op[0]
    input  logic                               i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // slot_used[13:0], slot_key[77:14], eval_count[109:78], hit_count[141:110],
    // mismatch_count[173:142], zero[175:174]
    output logic [hkec_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // status[1:0]
    output logic [hkec_pkg::STATUS_W-1:0]      o_m_axis_tuser
);
    import hkec_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_PUSH  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [IDX_W-1:0]     r_clr, n_clr;
    logic [IDX_W-1:0]     r_slot, n_slot;
    logic [PROBE_W-1:0]   r_probe, n_probe;
    logic [KEY_W-1:0]     r_key, n_key;
    logic                 r_hit, n_hit;
    logic                 r_mm, n_mm;
    t_result              r_pend, n_pend;
    logic                 r_ovalid;
    t_result              r_out;

    logic                 w_we;
    logic [IDX_W-1:0]     w_waddr;
    t_entry               w_wdata;
    logic [IDX_W-1:0]     w_raddr;
    logic [ENTRY_W-1:0]   w_rdata_raw;
    t_entry               w_rdata;
    logic                 w_hash_start;
    logic                 w_hash_done;
    logic [IDX_W-1:0]     w_hash_slot;
    t_result              w_res;
    logic                 w_res_vld;
    logic                 w_out_free;
    logic                 w_load;
    t_result              w_load_val;
    logic                 w_in_op;
    logic [KEY_W-1:0]     w_in_key;
    logic [SLOT_W-1:0]    w_in_slot;
    t_entry               w_upd;

    assign w_in_key  = i_s_axis_tdata[KEY_W-1:0];
    assign w_in_slot = i_s_axis_tdata[KEY_W+2 +: SLOT_W];
    assign w_in_op   = i_s_axis_tuser;
    assign w_rdata   = t_entry'(w_rdata_raw);
    assign w_out_free = !r_ovalid || i_m_axis_tready;

    hkec_ram #(
        .W (ENTRY_W),
        .D (TABLE_SLOTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_raw)
    );

    hkec_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_hash_start),
        .i_key   (w_in_key),
        .o_done  (w_hash_done),
        .o_slot  (w_hash_slot)
    );

    always_comb begin
        w_upd      = w_rdata;
        w_upd.key  = r_key;
        w_upd.eval = sat_inc(w_rdata.eval);
        if (r_hit) w_upd.hit = sat_inc(w_rdata.hit);
        if (r_mm)  w_upd.mm  = sat_inc(w_rdata.mm);
    end

    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_slot       = r_slot;
        n_probe      = r_probe;
        n_key        = r_key;
        n_hit        = r_hit;
        n_mm         = r_mm;
        n_pend       = r_pend;
        w_we         = 1'b0;
        w_waddr      = r_slot;
        w_wdata      = w_upd;
        w_raddr      = r_slot;
        w_hash_start = 1'b0;
        w_res        = '0;
        w_res_vld    = 1'b0;
        w_load       = 1'b0;
        w_load_val   = r_pend;

        case (r_state)
            ST_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = '0;
                n_clr   = r_clr + 1'b1;
                if (r_clr == IDX_W'(TABLE_SLOTS - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_key = w_in_key;
                    n_hit = i_s_axis_tdata[KEY_W];
                    n_mm  = i_s_axis_tdata[KEY_W+1];
                    if (w_in_op) begin
                        n_slot  = IDX_W'(w_in_slot);
                        w_raddr = IDX_W'(w_in_slot);
                        n_state = ST_READ;
                    end else if (w_in_key == '0) begin
                        w_res.status = STAT_ZERO_KEY;
                        w_res_vld    = 1'b1;
                    end else begin
                        w_hash_start = 1'b1;
                        n_state      = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                if (w_hash_done) begin
                    w_raddr = w_hash_slot;
                    n_slot  = w_hash_slot;
                    n_probe = '0;
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (w_rdata.key == r_key || w_rdata.key == '0) begin
                    w_we         = 1'b1;
                    w_res.status = STAT_RECORDED;
                    w_res.slot   = SLOT_W'(r_slot);
                    w_res.key    = r_key;
                    w_res.eval   = CNT_OUT_W'(w_upd.eval);
                    w_res.hit    = CNT_OUT_W'(w_upd.hit);
                    w_res.mm     = CNT_OUT_W'(w_upd.mm);
                    w_res_vld    = 1'b1;
                end else if (r_probe == PROBE_W'(PROBE_LIMIT - 1)) begin
                    w_res.status = STAT_FULL;
                    w_res_vld    = 1'b1;
                end else begin
                    n_slot  = (r_slot == IDX_W'(TABLE_SLOTS - 1)) ? '0 : r_slot + 1'b1;
                    w_raddr = n_slot;
                    n_probe = r_probe + 1'b1;
                end
            end
            ST_READ: begin
                w_res.status = STAT_READ;
                w_res.slot   = SLOT_W'(r_slot);
                w_res.key    = w_rdata.key;
                w_res.eval   = CNT_OUT_W'(w_rdata.eval);
                w_res.hit    = CNT_OUT_W'(w_rdata.hit);
                w_res.mm     = CNT_OUT_W'(w_rdata.mm);
                w_res_vld    = 1'b1;
            end
            ST_PUSH: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_res_vld) begin
            if (w_out_free) begin
                w_load     = 1'b1;
                w_load_val = w_res;
                n_state    = ST_IDLE;
            end else begin
                n_pend  = w_res;
                n_state = ST_PUSH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_probe <= n_probe;
        r_key   <= n_key;
        r_hit   <= n_hit;
        r_mm    <= n_mm;
        r_pend  <= n_pend;
        if (w_load) r_out <= w_load_val;
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = pack_out(r_out);
    assign o_m_axis_tuser  = r_out.status;

endmodule

### rtl/hkec_chk.sv
module hkec_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic [hkec_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    input logic                               i_s_axis_tuser,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [hkec_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input logic [hkec_pkg::STATUS_W-1:0]      o_m_axis_tuser
);
    import hkec_pkg::*;

    logic w_in_beat;
    logic [KEY_W-1:0] w_in_key;
    logic [KEY_W-1:0] w_out_key;
    logic [CNT_OUT_W-1:0] w_out_eval;

    assign w_in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_key   = i_s_axis_tdata[KEY_W-1:0];
    assign w_out_key  = o_m_axis_tdata[SLOT_W +: KEY_W];
    assign w_out_eval = o_m_axis_tdata[SLOT_W+KEY_W +: CNT_OUT_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("output beat changed while stalled");

    // zero-key records may finish on the accept edge; everything else occupies the block
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat && (i_s_axis_tuser || w_in_key != '0) |=> !o_s_axis_tready)
        else $error("input taken while an item is in flight");

    a_no_count_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser == STAT_ZERO_KEY || o_m_axis_tuser == STAT_FULL)
            |-> o_m_axis_tdata == '0)
        else $error("ignored or full result carries slot data");

    a_recorded_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == STAT_RECORDED
            |-> w_out_key != '0 && w_out_eval != '0)
        else $error("recorded result without key or evaluation count");

endmodule

bind hashed_key_event_counter hkec_chk u_hkec_chk (.*);

### sim/tb_hashed_key_event_counter.sv
module tb_hashed_key_event_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import hkec_pkg::*;

    localparam bit OP_RECORD   = 1'b0;
    localparam bit OP_READ     = 1'b1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int STALL_LEN   = 300;
    localparam int IDLE_PCT    = 22;

    typedef struct packed {
        bit              op;
        bit [KEY_W-1:0]  key;
        bit              hit;
        bit              mm;
        bit [SLOT_W-1:0] read_slot;
    } t_stim_item;

    logic                   i_clk;
    logic                   i_rst_n         = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    // key[63:0], hit_flag[64], mismatch_flag[65], read_slot[79:66]
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;
    // op[0]
    logic                   i_s_axis_tuser  = 1'b0;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // slot_used[13:0], slot_key[77:14], eval_count[109:78], hit_count[141:110],
    // mismatch_count[173:142], zero[175:174]
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;
    // status[1:0]
    logic [STATUS_W-1:0]    o_m_axis_tuser;

    hashed_key_event_counter DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // table mirror
    bit [KEY_W-1:0]      tbl_key  [TABLE_SLOTS];
    bit [COUNT_BITS-1:0] tbl_eval [TABLE_SLOTS];
    bit [COUNT_BITS-1:0] tbl_hit  [TABLE_SLOTS];
    bit [COUNT_BITS-1:0] tbl_mm   [TABLE_SLOTS];

    t_result        expected_results[$];
    bit [KEY_W-1:0] key_pool[$];
    int unsigned    counted_slots[$];
    bit [59:0]      group_bases[$];
    int             mismatch_total = 0;
    bit             steady         = 1'b0;
    bit             stall_pending  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        int cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb_hashed_key_event_counter failed");
        $finish;
    end

    function automatic int unsigned home_slot(input bit [KEY_W-1:0] k);
        bit [63:0] h;
        h = (k >> KEY_PRESHIFT) * HASH_MULT;
        return int'(h >> (64 - IDX_W)) % TABLE_SLOTS;
    endfunction

    function automatic bit [COUNT_BITS-1:0] bump(input bit [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // updates the mirror and returns the beat the block must produce
    function automatic t_result apply_item(input t_stim_item it);
        t_result     r;
        int unsigned s;
        bit          placed;
        r      = '0;
        placed = 1'b0;
        if (it.op == OP_READ) begin
            s      = it.read_slot % TABLE_SLOTS;
            placed = 1'b1;
        end else if (it.key != '0) begin
            s = home_slot(it.key);
            for (int p = 0; p < PROBE_LIMIT && !placed; p++) begin
                if (tbl_key[s] == it.key) begin
                    placed = 1'b1;
                end else if (tbl_key[s] == '0) begin
                    tbl_key[s] = it.key;
                    placed     = 1'b1;
                end else begin
                    s = (s + 1) % TABLE_SLOTS;
                end
            end
            if (placed) begin
                tbl_eval[s] = bump(tbl_eval[s]);
                if (it.hit)
                    tbl_hit[s] = bump(tbl_hit[s]);
                if (it.mm)
                    tbl_mm[s] = bump(tbl_mm[s]);
                counted_slots.insert(counted_slots.size(), s);
            end
        end
        if (it.op == OP_READ)
            r.status = STAT_READ;
        else if (it.key == '0)
            r.status = STAT_ZERO_KEY;
        else if (!placed)
            r.status = STAT_FULL;
        else
            r.status = STAT_RECORDED;
        if (placed) begin
            r.slot = SLOT_W'(s);
            r.key  = tbl_key[s];
            r.eval = tbl_eval[s][CNT_OUT_W-1:0];
            r.hit  = tbl_hit[s][CNT_OUT_W-1:0];
            r.mm   = tbl_mm[s][CNT_OUT_W-1:0];
        end
        return r;
    endfunction

    function automatic t_stim_item mk(input bit op, input bit [KEY_W-1:0] k, input bit h,
                                      input bit m, input bit [SLOT_W-1:0] rs);
        t_stim_item it;
        it.op        = op;
        it.key       = k;
        it.hit       = h;
        it.mm        = m;
        it.read_slot = rs;
        return it;
    endfunction

    function automatic t_stim_item random_item();
        t_stim_item it;
        int         pick;
        it   = mk(OP_RECORD, {$urandom, $urandom}, 1'($urandom), 1'($urandom),
                  SLOT_W'($urandom));
        pick = $urandom_range(99);
        if (pick < 50 && key_pool.size() > 0) begin
            it.key = key_pool[$urandom_range(key_pool.size() - 1)];
        end else if (pick >= 62 && pick < 67) begin
            it.key = '0;
        end else if (pick >= 67) begin
            it.op = OP_READ;
            if (pick < 87 && counted_slots.size() > 0)
                it.read_slot =
                    SLOT_W'(counted_slots[$urandom_range(counted_slots.size() - 1)]);
        end
        return it;
    endfunction

    // key bases whose nibble variants all share one home slot
    function automatic void find_bases(input int unsigned target, input int n);
        bit [59:0] b;
        group_bases.delete();
        b = 60'({$urandom, $urandom});
        while (group_bases.size() < n) begin
            if (b != '0 && home_slot({b, 4'h0}) == target)
                group_bases.insert(group_bases.size(), b);
            b++;
        end
    endfunction

    task automatic send_item(input t_stim_item it);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {it.read_slot, it.mm, it.hit, it.key};
        i_s_axis_tuser  <= it.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
        expected_results.insert(expected_results.size(), apply_item(it));
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // result side: random back-pressure, long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_pending) begin
                stall_pending = 1'b0;
                stall_left    = STALL_LEN;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation pending");
                mismatch_total++;
            end else begin
                want = expected_results.pop_front();
                check_field("status", 64'(want.status), 64'(o_m_axis_tuser));
                check_field("slot_used", 64'(want.slot), 64'(o_m_axis_tdata[SLOT_W-1:0]));
                check_field("slot_key", want.key, o_m_axis_tdata[SLOT_W +: KEY_W]);
                check_field("eval_count", 64'(want.eval),
                            64'(o_m_axis_tdata[SLOT_W+KEY_W +: CNT_OUT_W]));
                check_field("hit_count", 64'(want.hit),
                            64'(o_m_axis_tdata[SLOT_W+KEY_W+CNT_OUT_W +: CNT_OUT_W]));
                check_field("mismatch_count", 64'(want.mm),
                            64'(o_m_axis_tdata[SLOT_W+KEY_W+2*CNT_OUT_W +: CNT_OUT_W]));
            end
        end
    end

    task automatic test_directed();
        send_item(mk(OP_READ, {$urandom, $urandom}, 1'b1, 1'b1, '0));
        send_item(mk(OP_READ, '0, 1'b0, 1'b0, '1));
        send_item(mk(OP_RECORD, '0, 1'b1, 1'b1, '1));
        send_item(mk(OP_RECORD, '0, 1'b0, 1'b0, '0));
        send_item(mk(OP_RECORD, '1, 1'b1, 1'b1, '0));
        send_item(mk(OP_RECORD, '1, 1'b0, 1'b0, '1));
        send_item(mk(OP_RECORD, '1, 1'b1, 1'b0, '0));
        // keys below 16 all land on slot 0
        send_item(mk(OP_RECORD, 64'd1, 1'b0, 1'b1, '0));
        send_item(mk(OP_RECORD, 64'd15, 1'b1, 1'b0, '0));
        send_item(mk(OP_RECORD, 64'h8000_0000_0000_0000, 1'b1, 1'b1, '1));
        send_item(mk(OP_RECORD, 64'h10, 1'b0, 1'b0, '0));
        send_item(mk(OP_READ, '0, 1'b0, 1'b0, SLOT_W'(home_slot('1))));
        send_item(mk(OP_READ, '1, 1'b1, 1'b1, SLOT_W'(1)));
        send_item(mk(OP_READ, '0, 1'b0, 1'b0, '0));
    endtask

    // cluster at the top of the table wraps into slot 0 and past its occupants
    task automatic test_probe_wrap();
        find_bases(TABLE_SLOTS - 4, 1);
        for (int n = 0; n < 16; n++)
            send_item(mk(OP_RECORD, {group_bases[0], 4'(n)}, 1'($urandom), 1'($urandom),
                         SLOT_W'($urandom)));
        send_item(mk(OP_RECORD, {group_bases[0], 4'hF}, 1'b1, 1'b1, '0));
        send_item(mk(OP_READ, '0, 1'b0, 1'b0, '1));
        send_item(mk(OP_READ, '0, 1'b0, 1'b0, SLOT_W'(2)));
    endtask

    // 80 keys on one home slot: the last 16 exhaust the probe window
    task automatic test_table_full();
        int unsigned home;
        home = $urandom_range(2000, 14000);
        find_bases(home, 5);
        for (int g = 0; g < 5; g++)
            for (int n = 0; n < 16; n++)
                send_item(mk(OP_RECORD, {group_bases[g], 4'(n)}, 1'($urandom),
                             1'($urandom), SLOT_W'($urandom)));
        send_item(mk(OP_RECORD, {group_bases[0], 4'h0}, 1'b1, 1'b0, '0));
        send_item(mk(OP_RECORD, {group_bases[3], 4'hF}, 1'b1, 1'b1, '0));
        send_item(mk(OP_RECORD, {group_bases[4], 4'h7}, 1'b0, 1'b1, '0));
        send_item(mk(OP_READ, '0, 1'b0, 1'b0, SLOT_W'(home)));
        send_item(mk(OP_READ, '0, 1'b0, 1'b0, SLOT_W'(home + PROBE_LIMIT - 1)));
        for (int g = 0; g < 5; g++)
            key_pool.insert(key_pool.size(), {group_bases[g], 4'($urandom)});
    endtask

    task automatic test_random_mix(input int count);
        bit [59:0] b;
        for (int k = 0; k < 14; k++)
            key_pool.insert(key_pool.size(), {$urandom, $urandom});
        for (int g = 0; g < 6; g++) begin
            b = 60'({$urandom, $urandom});
            for (int n = 0; n < 4; n++)
                key_pool.insert(key_pool.size(), {b, 4'($urandom)});
        end
        for (int k = 0; k < count; k++)
            send_item(random_item());
    endtask

    task automatic test_output_stall();
        stall_pending = 1'b1;
        for (int k = 0; k < 8; k++)
            send_item(random_item());
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        for (int k = 0; k < 150; k++)
            send_item(random_item());
        steady = 1'b0;
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        drain();
        test_probe_wrap();
        drain();
        test_table_full();
        drain();
        test_random_mix(900);
        drain();
        test_output_stall();
        drain();
        test_back_to_back();
        drain();
        repeat (100) @(negedge i_clk);
        if (mismatch_total == 0 && expected_results.size() == 0)
            $display("tb_hashed_key_event_counter passed");
        else
            $display("tb_hashed_key_event_counter failed");
        $finish;
    end

endmodule
